### rtl/assert_macros.svh
// Assertion macros used by the RTL of the sorted priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define SPQ_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/spq_pkg.sv
// Types, codes and constants of the sorted priority queue.
`default_nettype none

package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;

	typedef logic [15:0]        id_t;
	typedef logic signed [15:0] pri_t;
	typedef logic [6:0]         cnt_out_t;

	localparam pri_t PRI_MAX = 16'sh7FFF;
	localparam pri_t PRI_MIN = -16'sh8000;

	// Request kinds.
	typedef enum logic [1:0] {
		KIND_INSERT   = 2'd0,
		KIND_INCREASE = 2'd1,
		KIND_CHANGE   = 2'd2,
		KIND_PEEK     = 2'd3
	} kind_t;

	// Response status codes.
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_REMOVE,
		ST_INSERT,
		ST_REPORT
	} state_t;

	// Operation broadcast to every cell.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_MATCH,
		CELL_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		id_t      id;
		pri_t     pri;
	} cell_cmd_t;

endpackage

`default_nettype wire

### rtl/spq_req_if.sv
// Request channel of the sorted priority queue.
`default_nettype none

interface spq_req_if;
	import spq_pkg::*;

	logic  valid;
	logic  ready;
	kind_t kind;
	id_t   item_id;
	pri_t  value;

	modport source (output valid, output kind, output item_id, output value, input ready);
	modport sink (input valid, input kind, input item_id, input value, output ready);
endinterface

`default_nettype wire

### rtl/spq_rsp_if.sv
// Response channel of the sorted priority queue.
`default_nettype none

interface spq_rsp_if;
	import spq_pkg::*;

	logic     valid;
	logic     ready;
	status_t  status;
	id_t      head_id;
	pri_t     head_priority;
	cnt_out_t entry_count;

	modport source (output valid, output status, output head_id, output head_priority,
		output entry_count, input ready);
	modport sink (input valid, input status, input head_id, input head_priority,
		input entry_count, output ready);
endinterface

`default_nettype wire

### rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none

module spq_cell (
	input  wire                     clk,
	input  wire spq_pkg::cell_cmd_t cmd,
	input  wire                     occ,
	input  wire spq_pkg::id_t       left_id,
	input  wire spq_pkg::pri_t      left_pri,
	input  wire                     left_gt,
	input  wire spq_pkg::id_t       right_id,
	input  wire spq_pkg::pri_t      right_pri,
	input  wire                     take_right,
	output spq_pkg::id_t            id,
	output spq_pkg::pri_t           pri,
	output logic                    gt,
	output logic                    match
);
	import spq_pkg::*;

	id_t  id_q;
	pri_t pri_q;
	logic match_q;

	// This slot stays in front of the new entry only if strictly higher.
	assign gt    = occ && (pri_q > cmd.pri);
	assign id    = id_q;
	assign pri   = pri_q;
	assign match = match_q;

	// Insert shifts toward the tail, remove pulls from the tail side.
	always_ff @(posedge clk) begin
		case (cmd.op)
			CELL_INSERT: begin
				if (!gt) begin
					if (left_gt) begin
						id_q  <= cmd.id;
						pri_q <= cmd.pri;
					end else begin
						id_q  <= left_id;
						pri_q <= left_pri;
					end
				end
			end
			CELL_MATCH: begin
				match_q <= occ && (id_q == cmd.id);
			end
			CELL_REMOVE: begin
				if (take_right) begin
					id_q  <= right_id;
					pri_q <= right_pri;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

`default_nettype wire

### rtl/sorted_priority_queue.sv
// Sorted priority queue built as a chain of shifting slot cells.
//
// Requests arrive on req (kind, item_id, value) and each produces exactly one
// response on rsp (status, head_id, head_priority, entry_count). Entries sit in
// a row of QUEUE_DEPTH cells ordered by priority, highest in cell 0. An insert
// is a broadcast in which every cell keeps, takes the new entry or takes its
// left neighbor. A key change is a match cycle, a removal cycle that shifts
// the tail down by one, and an insert cycle.
// Insert and peek pass the exec and report states, an unknown id passes exec,
// remove and report, a successful key change exec, remove, insert and report.
// One request is in work at a time; the next one is taken the cycle after the
// response is loaded; all share the single broadcast path into the cell row.
// The response register holds a finished result while the next request is
// already taken; if the receiver stalls, the block waits before loading the
// next result. Reset empties the queue at once (no clearing pass); slot
// contents are not reset and are never read before they are written.
`default_nettype none

`include "assert_macros.svh"

module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [QUEUE_DEPTH-1:0] ALL_ONES = {QUEUE_DEPTH{1'b1}};

	state_t           state_q, state_d;
	kind_t            kind_q;
	id_t              id_q;
	pri_t             val_q;
	pri_t             newpri_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;

	logic     rsp_valid_q;
	status_t  rsp_status_q;
	id_t      rsp_id_q;
	pri_t     rsp_pri_q;
	cnt_out_t rsp_count_q;

	cell_cmd_t cmd;
	logic      cnt_inc, cnt_dec, set_status, load_rsp, load_newpri;
	status_t   status_d;

	id_t                    id_a  [QUEUE_DEPTH];
	pri_t                   pri_a [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] gt_a, match_a, occ_a, incl_a, first_a;

	logic        found;
	pri_t        found_pri;
	logic [16:0] sum;
	pri_t        newpri_d;

	// Row of slot cells with neighbor links.
	for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
		assign occ_a[k] = CNT_W'(k) < count_q;
		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (occ_a[k]),
			.left_id    ((k == 0) ? id_q : id_a[(k == 0) ? 0 : k - 1]),
			.left_pri   ((k == 0) ? val_q : pri_a[(k == 0) ? 0 : k - 1]),
			.left_gt    ((k == 0) ? 1'b1 : gt_a[(k == 0) ? 0 : k - 1]),
			.right_id   (id_a[(k == QUEUE_DEPTH - 1) ? k : k + 1]),
			.right_pri  (pri_a[(k == QUEUE_DEPTH - 1) ? k : k + 1]),
			.take_right (incl_a[k]),
			.id         (id_a[k]),
			.pri        (pri_a[k]),
			.gt         (gt_a[k]),
			.match      (match_a[k])
		);
		// A cell pulls from the right once the first match lies at or before it.
		assign incl_a[k] = |(match_a & (ALL_ONES >> (QUEUE_DEPTH - 1 - k)));
		if (k == 0) begin : g_first0
			assign first_a[k] = incl_a[k];
		end else begin : g_firstk
			assign first_a[k] = incl_a[k] & ~incl_a[k-1];
		end
	end

	assign found = incl_a[QUEUE_DEPTH-1];

	// Priority of the first matching entry, then the new key.
	always_comb begin
		found_pri = '0;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			found_pri = found_pri | (first_a[k] ? pri_a[k] : '0);
		end
		sum = {found_pri[15], found_pri} + {val_q[15], val_q};
		if (kind_q == KIND_CHANGE) begin
			newpri_d = val_q;
		end else if (sum[16] != sum[15]) begin
			newpri_d = sum[16] ? PRI_MIN : PRI_MAX;
		end else begin
			newpri_d = pri_t'(sum[15:0]);
		end
	end

	// Sequencer: next state and the broadcast command.
	always_comb begin
		state_d     = state_q;
		cmd.op      = CELL_HOLD;
		cmd.id      = id_q;
		cmd.pri     = val_q;
		cnt_inc     = 1'b0;
		cnt_dec     = 1'b0;
		set_status  = 1'b0;
		status_d    = STAT_OK;
		load_rsp    = 1'b0;
		load_newpri = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (kind_q)
					KIND_INSERT: begin
						state_d = ST_REPORT;
						if (count_q == DEPTH_CNT) begin
							set_status = 1'b1;
							status_d   = STAT_FULL;
						end else begin
							cmd.op  = CELL_INSERT;
							cnt_inc = 1'b1;
						end
					end
					KIND_PEEK: begin
						state_d = ST_REPORT;
						if (count_q == '0) begin
							set_status = 1'b1;
							status_d   = STAT_EMPTY;
						end
					end
					default: begin
						cmd.op  = CELL_MATCH;
						state_d = ST_REMOVE;
					end
				endcase
			end
			ST_REMOVE: begin
				if (found) begin
					cmd.op      = CELL_REMOVE;
					cnt_dec     = 1'b1;
					load_newpri = 1'b1;
					state_d     = ST_INSERT;
				end else begin
					set_status = 1'b1;
					status_d   = STAT_NOT_FOUND;
					state_d    = ST_REPORT;
				end
			end
			ST_INSERT: begin
				cmd.op  = CELL_INSERT;
				cmd.pri = newpri_q;
				cnt_inc = 1'b1;
				state_d = ST_REPORT;
			end
			ST_REPORT: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request and response payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			kind_q   <= req.kind;
			id_q     <= req.item_id;
			val_q    <= req.value;
			status_q <= STAT_OK;
		end else if (set_status) begin
			status_q <= status_d;
		end
		if (load_newpri) begin
			newpri_q <= newpri_d;
		end
		if (load_rsp) begin
			rsp_status_q <= status_q;
			rsp_id_q     <= (count_q != '0) ? id_a[0] : '0;
			rsp_pri_q    <= (count_q != '0) ? pri_a[0] : '0;
			rsp_count_q  <= cnt_out_t'(count_q);
		end
	end

	assign req.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.head_id       = rsp_id_q;
	assign rsp.head_priority = rsp_pri_q;
	assign rsp.entry_count   = rsp_count_q;

	// Checks on the queue bookkeeping.
	`SPQ_ASSERT(a_count_bound, count_q <= DEPTH_CNT, "entry count above queue depth")
	`SPQ_ASSERT_NEXT(a_remove_dec, (state_q == ST_REMOVE) && found, count_q == $past(count_q) - CNT_W'(1), "removal did not drop the count")
	`SPQ_ASSERT(a_head_order, !((state_q == ST_IDLE) && (count_q >= CNT_W'(2))) || (pri_a[0] >= pri_a[1]), "head slots out of priority order")
endmodule

`default_nettype wire
